>>> design/lkc_pkg.sv
package lkc_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_EVICT  = 2'd2;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;
    localparam int LIVE_W  = 5;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic              found;
        logic              replaced_oldest;
        logic [LIVE_W-1:0] live_entries;
        logic [CNT_W-1:0]  hits_total;
        logic [CNT_W-1:0]  misses_total;
        logic [CNT_W-1:0]  evictions_total;
    } result_t;

    // control from the sequencer to the table
    typedef struct packed {
        logic       scan_go;
        logic       commit;
        logic       need_oldest;
        logic [1:0] command;
    } ctl_t;

    // table status back to the sequencer
    typedef struct packed {
        logic scan_done;
        logic match_hit;
        logic evicted;
        logic added;
    } sts_t;

endpackage

>>> design/lru_key_cache_with_stats_unit.sv
// Channel   | Signals             | Handshake
// ----------+---------------------+--------------------------------------
// request   | start, busy, item   | taken at edge with start && !busy
// result    | done, result        | one-cycle strobe, no back-pressure
// config    | cfg_we, cfg_wdata   | capacity limit written when cfg_we high
//
// busy stays high from the accepting edge until the commit. The scan makes
// one memory read per entry, then drains the read pipeline and commits.
// The result strobe follows in the next cycle with busy already low, so a new
// transaction may be taken there; a new start is never taken while busy.
// Reset clears valid bits, tick, counters and limit; key/stamp memories are
// used only for valid slots. The receiver cannot stall: done lasts one cycle.
module lru_key_cache_with_stats_unit #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lkc_pkg::item_t   item,
    output logic             done,
    output lkc_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata
);
    import lkc_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               state_reg;
    logic               state_next;
    item_t              req_reg;
    logic               need_old_reg;
    logic [4:0]         lim_reg;
    logic [STAMP_W-1:0] tick_reg;
    logic [LW-1:0]      live_reg;
    logic [LW-1:0]      live_next;
    logic [CNT_W-1:0]   hit_reg;
    logic [CNT_W-1:0]   hit_next;
    logic [CNT_W-1:0]   miss_reg;
    logic [CNT_W-1:0]   miss_next;
    logic [CNT_W-1:0]   evc_reg;
    logic [CNT_W-1:0]   evc_next;
    logic               done_reg;
    result_t            res_reg;
    result_t            res_next;

    logic               accept;
    logic               commit;
    logic               evict_needed;
    ctl_t               ctl;
    sts_t               sts;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign commit = (state_reg == ST_SCAN) && sts.scan_done;
    assign done   = done_reg;
    assign result = res_reg;

    // limit 0 or above depth means the whole table
    assign evict_needed = (32'(live_reg) >= DEPTH) ||
                          ((lim_reg != 5'd0) && (32'(live_reg) >= 32'(lim_reg)));

    assign ctl.scan_go     = accept;
    assign ctl.commit      = commit;
    assign ctl.need_oldest = need_old_reg;
    assign ctl.command     = req_reg.command;

    lkc_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .key   (req_reg.key),
        .stamp (tick_reg),
        .sts   (sts)
    );

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = ST_SCAN;
        end
        else if (commit)
        begin
            state_next = ST_IDLE;
        end
    end

    // statistics and result for the committing transaction
    always_comb
    begin
        live_next = live_reg;
        hit_next  = hit_reg;
        miss_next = miss_reg;
        evc_next  = evc_reg;
        res_next.found           = 1'b0;
        res_next.replaced_oldest = 1'b0;
        unique case (req_reg.command)
            CMD_LOOKUP:
            begin
                res_next.found = sts.match_hit;
                if (sts.match_hit)
                begin
                    hit_next = hit_reg + CNT_W'(1);
                end
                else
                begin
                    miss_next = miss_reg + CNT_W'(1);
                end
            end
            CMD_RECORD:
            begin
                res_next.replaced_oldest = sts.evicted;
                if (sts.evicted)
                begin
                    evc_next = evc_reg + CNT_W'(1);
                end
                if (sts.added && !sts.evicted)
                begin
                    live_next = live_reg + LW'(1);
                end
                else if (!sts.added && sts.evicted)
                begin
                    live_next = live_reg - LW'(1);
                end
            end
            CMD_EVICT:
            begin
                res_next.found = sts.match_hit;
                if (sts.match_hit)
                begin
                    evc_next  = evc_reg + CNT_W'(1);
                    live_next = live_reg - LW'(1);
                end
            end
            default:
            begin
                res_next.found = 1'b0;
            end
        endcase
        res_next.live_entries    = LIVE_W'(live_next);
        res_next.hits_total      = hit_next;
        res_next.misses_total    = miss_next;
        res_next.evictions_total = evc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            need_old_reg <= 1'b0;
            lim_reg      <= '0;
            tick_reg     <= '0;
            live_reg     <= '0;
            hit_reg      <= '0;
            miss_reg     <= '0;
            evc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= commit;
            if (cfg_we)
            begin
                lim_reg <= cfg_wdata;
            end
            if (accept)
            begin
                need_old_reg <= (item.command == CMD_RECORD) && evict_needed;
                // tick advances on lookup and record only
                if ((item.command == CMD_LOOKUP) || (item.command == CMD_RECORD))
                begin
                    tick_reg <= tick_reg + STAMP_W'(1);
                end
            end
            if (commit)
            begin
                live_reg <= live_next;
                hit_reg  <= hit_next;
                miss_reg <= miss_next;
                evc_reg  <= evc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= item;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(commit))
        else $error("result strobe without commit");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= DEPTH)
        else $error("live count above table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accepting a transaction");

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        sts.scan_done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside scan state");
`endif

endmodule

>>> design/lkc_table.sv
module lkc_table #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkc_pkg::ctl_t               ctl,
    input  logic [lkc_pkg::KEY_W-1:0]   key,
    input  logic [lkc_pkg::STAMP_W-1:0] stamp,
    output lkc_pkg::sts_t               sts
);
    import lkc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_W-1:0]   key_mem   [DEPTH];
    logic [STAMP_W-1:0] stamp_mem [DEPTH];
    logic [KEY_W-1:0]   rd_key_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    logic [DEPTH-1:0]   valid_reg;
    logic               scan_on_reg;
    logic [AW-1:0]      cnt_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               done_reg;

    logic               match_f_reg;
    logic [AW-1:0]      match_idx_reg;
    logic               old_f_reg;
    logic [AW-1:0]      old_idx_reg;
    logic [STAMP_W-1:0] old_stamp_reg;
    logic               free_f_reg;
    logic [AW-1:0]      free_idx_reg;

    logic               rd_valid;
    logic               evict;
    logic               match_ok;
    logic               use_old;
    logic               rec_ok;
    logic [AW-1:0]      rec_slot;
    logic [AW-1:0]      wr_idx;
    logic               wr_key_en;
    logic               wr_stamp_en;

    assign rd_valid = valid_reg[rd_idx_reg];

    // commit decision from the scan results
    assign evict    = ctl.need_oldest && old_f_reg;
    assign match_ok = match_f_reg && !(evict && (old_idx_reg == match_idx_reg));
    assign use_old  = evict && (!free_f_reg || (old_idx_reg < free_idx_reg));
    assign rec_ok   = match_ok || evict || free_f_reg;

    always_comb
    begin
        if (match_ok)
        begin
            rec_slot = match_idx_reg;
        end
        else if (use_old)
        begin
            rec_slot = old_idx_reg;
        end
        else
        begin
            rec_slot = free_idx_reg;
        end
    end

    always_comb
    begin
        wr_idx      = match_idx_reg;
        wr_key_en   = 1'b0;
        wr_stamp_en = 1'b0;
        unique case (ctl.command)
            CMD_LOOKUP:
            begin
                wr_stamp_en = ctl.commit && match_f_reg;
            end
            CMD_RECORD:
            begin
                wr_idx      = rec_slot;
                wr_key_en   = ctl.commit && rec_ok;
                wr_stamp_en = ctl.commit && rec_ok;
            end
            default:
            begin
                wr_key_en   = 1'b0;
            end
        endcase
    end

    assign sts.scan_done = done_reg;
    assign sts.match_hit = match_f_reg;
    assign sts.evicted   = (ctl.command == CMD_RECORD) && evict;
    assign sts.added     = (ctl.command == CMD_RECORD) && !match_ok && rec_ok;

    // key and stamp memories: one read and one write port
    always_ff @(posedge clk)
    begin
        if (scan_on_reg)
        begin
            rd_key_reg   <= key_mem[cnt_reg];
            rd_stamp_reg <= stamp_mem[cnt_reg];
        end
        if (wr_key_en)
        begin
            key_mem[wr_idx] <= key;
        end
        if (wr_stamp_en)
        begin
            stamp_mem[wr_idx] <= stamp;
        end
    end

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_on_reg <= 1'b0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= scan_on_reg;
            rd_idx_reg <= cnt_reg;
            done_reg   <= rd_vld_reg && (rd_idx_reg == AW'(DEPTH - 1));
            if (ctl.scan_go)
            begin
                scan_on_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (scan_on_reg)
            begin
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    scan_on_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
            end
        end
    end

    // match, oldest and first free trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_f_reg <= 1'b0;
            old_f_reg   <= 1'b0;
            free_f_reg  <= 1'b0;
        end
        else if (ctl.scan_go)
        begin
            match_f_reg <= 1'b0;
            old_f_reg   <= 1'b0;
            free_f_reg  <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_valid && !match_f_reg && (rd_key_reg == key))
            begin
                match_f_reg <= 1'b1;
            end
            if (rd_valid && (!old_f_reg || (rd_stamp_reg < old_stamp_reg)))
            begin
                old_f_reg <= 1'b1;
            end
            if (!rd_valid && !free_f_reg)
            begin
                free_f_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && !ctl.scan_go)
        begin
            if (rd_valid && !match_f_reg && (rd_key_reg == key))
            begin
                match_idx_reg <= rd_idx_reg;
            end
            if (rd_valid && (!old_f_reg || (rd_stamp_reg < old_stamp_reg)))
            begin
                old_idx_reg   <= rd_idx_reg;
                old_stamp_reg <= rd_stamp_reg;
            end
            if (!rd_valid && !free_f_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // valid bits; a set after the eviction clear wins on the same slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.commit)
        begin
            unique case (ctl.command)
                CMD_RECORD:
                begin
                    if (evict)
                    begin
                        valid_reg[old_idx_reg] <= 1'b0;
                    end
                    if (rec_ok)
                    begin
                        valid_reg[rec_slot] <= 1'b1;
                    end
                end
                CMD_EVICT:
                begin
                    if (match_f_reg)
                    begin
                        valid_reg[match_idx_reg] <= 1'b0;
                    end
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(rd_vld_reg) && !scan_on_reg)
        else $error("scan done without final read");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_on_reg |-> !wr_key_en && !wr_stamp_en)
        else $error("memory write during scan");

    a_valid_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |=> $stable(valid_reg) || $past(ctl.commit))
        else $error("valid bits changed during scan");
`endif

endmodule

>>> sim/tb.sv
module tb;
    import lkc_pkg::*;

    localparam int DEPTH  = 16;
    localparam int POOL_N = 20;

    // command 3 has no name in the package; the block treats it as a no-op
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [63:0] KEY_MIN = 64'h0000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_MSB = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_A   = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] KEY_B   = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] KEY_C   = 64'h5555_AAAA_5555_AAAA;
    localparam logic [63:0] KEY_D   = 64'hAAAA_5555_AAAA_5555;
    localparam logic [63:0] KEY_E   = 64'h0000_0001_0000_0001;
    localparam logic [63:0] KEY_F   = 64'h7FFF_FFFF_FFFF_FFFE;
    localparam logic [63:0] KEY_G   = 64'hC0DE_0000_0000_BEEF;

    typedef enum logic { ROW_ITEM, ROW_LIMIT } row_kind_t;

    // one line of the directed plan: either a transaction or a limit write
    typedef struct {
        row_kind_t  kind;
        logic [4:0] limit;
        item_t      it;
        bit         pinned;
        result_t    want;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    item_t      item;
    logic       done;
    result_t    result;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    // hand-typed expectation that rides along with the item being offered
    bit      pin_on;
    result_t pin_want;

    // shadow copy of the cache and its statistics
    bit          slot_used [DEPTH];
    logic [63:0] slot_key  [DEPTH];
    logic [63:0] slot_stamp[DEPTH];
    logic [63:0] use_tick  = '0;
    logic [31:0] n_hits    = '0;
    logic [31:0] n_misses  = '0;
    logic [31:0] n_evicts  = '0;
    logic [4:0]  limit_reg = '0;

    result_t     cache_results_q[$];
    result_t     head;
    logic [63:0] key_pool[POOL_N];
    bit          idle_on   = 1'b1;
    int          errors    = 0;
    int          n_checked = 0;
    int          n_replace = 0;
    int          n_found   = 0;

    lru_key_cache_with_stats_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow cache
    // ---------------------------------------------------------------
    function automatic int find_slot(input logic [63:0] k);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_used[i] && slot_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            n += slot_used[i];
        return n;
    endfunction

    // Advances the shadow state by one transaction and returns the result
    // the block should report for it.
    function automatic result_t lru_predict(input item_t it);
        result_t r;
        int      slot;
        int      oldest;
        int      cap;
        r = '0;
        case (it.command)
            CMD_LOOKUP:
            begin
                use_tick++;
                slot = find_slot(it.key);
                if (slot >= 0)
                begin
                    slot_stamp[slot] = use_tick;
                    n_hits++;
                    r.found = 1'b1;
                end
                else
                begin
                    n_misses++;
                end
            end
            CMD_RECORD:
            begin
                use_tick++;
                // zero, or anything past the table size, means the whole table
                cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
                // at capacity: drop the stalest entry first, even if it is
                // the key being recorded; only one entry goes per record
                if (occupancy() >= cap)
                begin
                    oldest = -1;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot_used[i] &&
                            (oldest < 0 || slot_stamp[i] < slot_stamp[oldest]))
                            oldest = i;
                    end
                    if (oldest >= 0)
                    begin
                        slot_used[oldest] = 1'b0;
                        n_evicts++;
                        r.replaced_oldest = 1'b1;
                    end
                end
                // surviving key is refreshed in place, else lowest free slot
                slot = find_slot(it.key);
                if (slot < 0)
                begin
                    for (int i = DEPTH - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                            slot = i;
                    end
                end
                if (slot >= 0)
                begin
                    slot_used[slot]  = 1'b1;
                    slot_key[slot]   = it.key;
                    slot_stamp[slot] = use_tick;
                end
            end
            CMD_EVICT:
            begin
                slot = find_slot(it.key);
                if (slot >= 0)
                begin
                    slot_used[slot] = 1'b0;
                    n_evicts++;
                    r.found = 1'b1;
                end
            end
            default:
                ; // unused code: no state change, stats echoed
        endcase
        r.live_entries    = LIVE_W'(occupancy());
        r.hits_total      = n_hits;
        r.misses_total    = n_misses;
        r.evictions_total = n_evicts;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: the edge values of start/busy/done/cfg_we are sampled here,
    // so the driver's nonblocking updates at the same edge never race it.
    // A result and a new transaction can share an edge; the result always
    // belongs to an older transaction, so it is checked first.
    // ---------------------------------------------------------------
    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (cache_results_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    head = cache_results_q.pop_front();
                    n_checked++;
                    n_replace += result.replaced_oldest;
                    n_found   += result.found;
                    if (result.found !== head.found)
                        report_field("found", head.found, result.found);
                    if (result.replaced_oldest !== head.replaced_oldest)
                        report_field("replaced_oldest", head.replaced_oldest,
                                     result.replaced_oldest);
                    if (result.live_entries !== head.live_entries)
                        report_field("live_entries", head.live_entries, result.live_entries);
                    if (result.hits_total !== head.hits_total)
                        report_field("hits_total", head.hits_total, result.hits_total);
                    if (result.misses_total !== head.misses_total)
                        report_field("misses_total", head.misses_total, result.misses_total);
                    if (result.evictions_total !== head.evictions_total)
                        report_field("evictions_total", head.evictions_total,
                                     result.evictions_total);
                end
            end
            if (cfg_we)
                limit_reg = cfg_wdata;
            if (start && !busy)
            begin
                head = lru_predict(item);
                cache_results_q.insert(cache_results_q.size(), pin_on ? pin_want : head);
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    // Offers one transaction and returns in the step of the edge that took
    // it. start stays high so a following call can go back to back.
    task automatic send_item(input item_t it, input bit pin, input result_t want);
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            start <= 1'b0;
            // gap lengths up to a full transaction, so pauses land on every phase
            repeat ($urandom_range(1, DEPTH + 4)) @(posedge clk);
        end
        start    <= 1'b1;
        item     <= it;
        pin_on   <= pin;
        pin_want <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops offering and waits until every outstanding result is back. The
    // first edge lets the monitor log a transaction taken in this step.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (cache_results_q.size() != 0)
            @(posedge clk);
    endtask

    // Limit writes only happen with the block idle.
    task automatic set_limit(input logic [4:0] v);
        settle();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic plan_row_t limit_row(input logic [4:0] v);
        plan_row_t row;
        row       = '{kind: ROW_LIMIT, limit: v, it: '0, pinned: 1'b0, want: '0};
        return row;
    endfunction

    function automatic plan_row_t item_row(input logic [1:0] cmd, input logic [63:0] k);
        plan_row_t row;
        row       = '{kind: ROW_ITEM, limit: '0, it: '0, pinned: 1'b0, want: '0};
        row.it    = '{command: cmd, key: k};
        return row;
    endfunction

    function automatic plan_row_t pinned_row(input logic [1:0] cmd, input logic [63:0] k,
                                             input bit f, input logic [4:0] live,
                                             input int h, input int m, input int e);
        plan_row_t row;
        row        = item_row(cmd, k);
        row.pinned = 1'b1;
        row.want   = '{found: f, replaced_oldest: 1'b0, live_entries: live,
                       hits_total: h, misses_total: m, evictions_total: e};
        return row;
    endfunction

    // Mostly keys from a small pool so lookups hit and the table fills up;
    // one in ten is a fresh random key.
    function automatic item_t random_item();
        item_t it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            it.command = CMD_LOOKUP;
        else if (roll < 75)
            it.command = CMD_RECORD;
        else if (roll < 93)
            it.command = CMD_EVICT;
        else
            it.command = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0)
            it.key = {$urandom, $urandom};
        else
            it.key = key_pool[$urandom_range(0, POOL_N - 1)];
        return it;
    endfunction

    initial
    begin
        plan_row_t  plan[$];
        logic [4:0] sweep[8];
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        pin_on    = 1'b0;
        pin_want  = '0;
        rst_n     = 1'b0;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < POOL_N; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed plan. Counters are typed in where they follow trivially
        // from reset; the LRU-order rows lean on the shadow cache.
        plan.insert(plan.size(), limit_row(5'd0));
        plan.insert(plan.size(), pinned_row(CMD_UNUSED, KEY_MIN, 0, 0, 0, 0, 0));
        plan.insert(plan.size(), pinned_row(CMD_LOOKUP, KEY_MIN, 0, 0, 0, 1, 0)); // miss on empty
        plan.insert(plan.size(), pinned_row(CMD_EVICT,  KEY_MAX, 0, 0, 0, 1, 0)); // absent key
        plan.insert(plan.size(), pinned_row(CMD_RECORD, KEY_MIN, 0, 1, 0, 1, 0));
        plan.insert(plan.size(), pinned_row(CMD_RECORD, KEY_MAX, 0, 2, 0, 1, 0));
        plan.insert(plan.size(), pinned_row(CMD_LOOKUP, KEY_MAX, 1, 2, 1, 1, 0)); // hit
        plan.insert(plan.size(), pinned_row(CMD_LOOKUP, KEY_MSB, 0, 2, 1, 2, 0));
        plan.insert(plan.size(), pinned_row(CMD_RECORD, KEY_MIN, 0, 2, 1, 2, 0)); // in place
        plan.insert(plan.size(), pinned_row(CMD_EVICT,  KEY_MIN, 1, 1, 1, 2, 1));
        plan.insert(plan.size(), pinned_row(CMD_UNUSED, 64'd5,   0, 1, 1, 2, 1));
        // limit of two: replacement order follows the stamps
        plan.insert(plan.size(), limit_row(5'd2));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_A));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_B));  // drops KEY_MAX
        plan.insert(plan.size(), item_row(CMD_LOOKUP, KEY_A));  // A now newest
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_B));  // B is oldest: drops itself
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_B));  // drops A, B survives
        // limit past the table size acts as full depth
        plan.insert(plan.size(), limit_row(5'd17));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_C));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_D));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_E));
        // limit dropped below occupancy: one entry out per record
        plan.insert(plan.size(), limit_row(5'd1));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_F));
        plan.insert(plan.size(), item_row(CMD_RECORD, KEY_G));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_LIMIT)
                set_limit(plan[i].limit);
            else
                send_item(plan[i].it, plan[i].pinned, plan[i].want);
        end

        // Random phases, each behind a limit write (which also drains the
        // block). Phase 2 runs with no idle gaps at all.
        sweep = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd0, 5'd8, 5'd0};
        sweep[5] = $urandom_range(0, 31);
        sweep[7] = $urandom_range(0, 31);
        for (int ph = 0; ph < 8; ph++)
        begin
            set_limit(sweep[ph]);
            idle_on = (ph != 2);
            repeat (64)
                send_item(random_item(), 1'b0, '0);
        end

        settle();
        // tail: any stray strobe after the last result gets flagged
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (cache_results_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, cache_results_q.size());
            errors++;
        end

        $display("checked %0d transactions: %0d hits or evict matches, %0d LRU replacements",
                 n_checked, n_found, n_replace);
        $display("capacity limits swept across 0, 1, 2, 3, 8, 16, 17, 31 plus random picks");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
